>>> rtl/ier_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_pkg
// Types, constants and helpers shared by the ICMPv6 echo responder.
// ----------------------------------------------------------------------------
package ier_pkg;

	localparam int MAX_ECHO_PAYLOAD_DEF = 256;
	localparam int MAX_FRAME_DEF        = 2048;

	// register indexes
	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_ADDR_HI  = 2'd1;
	localparam logic [1:0] REG_ADDR_LO  = 2'd2;
	localparam logic [1:0] REG_OUR_MAC  = 2'd3;

	// frame offsets
	localparam int OFF_MAC_SRC    = 6;
	localparam int OFF_MAC_END    = 11;
	localparam int OFF_ETYPE_HI   = 12;
	localparam int OFF_ETYPE_LO   = 13;
	localparam int OFF_PLEN_HI    = 18;
	localparam int OFF_PLEN_LO    = 19;
	localparam int OFF_NEXT_HDR   = 20;
	localparam int OFF_SRC_HI     = 22;
	localparam int OFF_SRC_LO     = 30;
	localparam int OFF_DST_HI     = 38;
	localparam int OFF_DST_LO     = 46;
	localparam int OFF_DST_END    = 53;
	localparam int OFF_ICMP       = 54;
	localparam int OFF_CSUM_HI    = 56;
	localparam int OFF_CSUM_LO    = 57;
	localparam int OFF_IDENT      = 58;
	localparam int OFF_IDENT_END  = 61;
	localparam int OFF_PAYLOAD    = 62;

	localparam logic [7:0]  ETYPE_HI       = 8'h86;
	localparam logic [7:0]  ETYPE_LO       = 8'hDD;
	localparam logic [7:0]  NH_ICMPV6      = 8'd58;
	localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd128;
	localparam logic [7:0]  ICMP_ECHO_REP  = 8'd129;
	localparam logic [4:0]  FLAGS_ALL      = 5'h1F;
	localparam logic [63:0] IP6_HDR_WORD0  = 64'h6000_0000_0000_3A40;

	// reply word order
	localparam int WORD_IP6      = 0;
	localparam int WORD_SRC_HI   = 1;
	localparam int WORD_SRC_LO   = 2;
	localparam int WORD_DST_HI   = 3;
	localparam int WORD_DST_LO   = 4;
	localparam int WORD_ICMP     = 5;
	localparam int WORD_PAYLOAD  = 6;

	typedef enum logic [1:0] {
		PS_ACC,
		PS_SUM,
		PS_CHECK
	} parse_state_t;

	typedef struct packed {
		logic        consumed;
		logic        reply;
		logic [47:0] mac;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [31:0] ident;
		logic [15:0] csum;
		logic [15:0] clip;
	} job_t;

	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [2:0]  lane;
		logic [7:0]  data;
	} pay_wr_t;

	typedef struct packed {
		logic        consumed;
		logic        is_reply;
		logic [47:0] mac;
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} res_t;

	// one's complement fold and invert
	function automatic logic [15:0] fold_sum(input logic [31:0] s);
		logic [16:0] a;
		logic [15:0] b;
		a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		b = a[15:0] + {15'd0, a[16]};
		return ~b;
	endfunction

endpackage

>>> rtl/ier_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_frame_if
// Receive byte channel: one frame byte per transaction.
// ----------------------------------------------------------------------------
interface ier_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source(output valid, output frame_byte, output last_byte, input ready);
	modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> rtl/ier_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_result_if
// Result channel: verdicts and reply packet words.
// ----------------------------------------------------------------------------
interface ier_result_if;
	logic        valid;
	logic        ready;
	logic        consumed;
	logic        is_reply;
	logic [47:0] reply_dst_mac;
	logic [63:0] reply_word;
	logic [3:0]  word_bytes;
	logic        last_item;

	modport source(output valid, output consumed, output is_reply, output reply_dst_mac,
		output reply_word, output word_bytes, output last_item, input ready);
	modport sink(input valid, input consumed, input is_reply, input reply_dst_mac,
		input reply_word, input word_bytes, input last_item, output ready);
endinterface

>>> rtl/ier_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_parser
// Front end: parses frame bytes, keeps checksums, writes payload, and
// issues one job per frame.
// ----------------------------------------------------------------------------
module ier_parser
	import ier_pkg::*;
#(
	parameter int MAX_ECHO_PAYLOAD = MAX_ECHO_PAYLOAD_DEF,
	parameter int MAX_FRAME        = MAX_FRAME_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ier_frame_if.sink    frame,
	input  logic         enable,
	input  logic [63:0]  our_addr_high,
	input  logic [63:0]  our_addr_low,
	output job_t         job,
	output logic         job_push,
	input  logic         job_full,
	output pay_wr_t      pay_wr,
	input  logic         reply_done
);

	localparam int PW = $clog2(MAX_FRAME + 1);

	parse_state_t state_q, state_nxt;

	logic [PW-1:0] pos_q, len_q;
	logic [47:0]   mac_q;
	logic [63:0]   src_hi_q, src_lo_q;
	logic [31:0]   ident_q;
	logic [15:0]   dlen_q, rcsum_q;
	logic [4:0]    flags_q;
	logic [31:0]   vsum_q, rsum_q;
	logic [1:0]    pend_q;

	logic [31:0] vsum_s1, rsum_s1;
	logic [15:0] clip_s1;
	logic        cons_s1, len_ok_s1;

	logic [7:0]    b;
	logic          take, upd, at_end;
	logic [15:0]   w;
	logic [4:0]    flags_b, flags_n;
	logic [31:0]   vsum_b, rsum_b, vsum_n, rsum_n;
	logic          in_dl, pay;
	logic [PW-1:0] pidx;
	logic [2:0]    k_hi, k_lo;
	logic [15:0]   clip_c;
	logic [15:0]   fold_v, fold_r;

	assign b      = frame.frame_byte;
	assign take   = frame.valid && frame.ready;
	assign upd    = take && (pos_q < PW'(MAX_FRAME));
	assign at_end = take && frame.last_byte;

	// byte update
	always_comb begin
		w       = pos_q[0] ? {8'd0, b} : {b, 8'd0};
		flags_b = (pos_q == '0) ? FLAGS_ALL : flags_q;
		vsum_b  = (pos_q == '0) ? 32'd0 : vsum_q;
		rsum_b  = (pos_q == '0) ? 32'd0 : rsum_q;
		in_dl   = (pos_q >= PW'(OFF_ICMP)) &&
			((32'(pos_q) - 32'(OFF_ICMP)) < 32'(dlen_q));
		pidx    = pos_q - PW'(OFF_PAYLOAD);
		pay     = (pos_q >= PW'(OFF_PAYLOAD)) && in_dl &&
			(32'(pidx) < 32'(MAX_ECHO_PAYLOAD));
		k_hi    = 3'(pos_q - PW'(OFF_DST_HI));
		k_lo    = 3'(pos_q - PW'(OFF_DST_LO));
		flags_n = flags_b;
		if ((pos_q == PW'(OFF_ETYPE_HI) && b != ETYPE_HI) ||
			(pos_q == PW'(OFF_ETYPE_LO) && b != ETYPE_LO))
			flags_n[0] = 1'b0;
		if (pos_q == PW'(OFF_NEXT_HDR) && b != NH_ICMPV6)
			flags_n[1] = 1'b0;
		if (pos_q >= PW'(OFF_DST_HI) && pos_q < PW'(OFF_DST_LO) &&
			our_addr_high[{~k_hi, 3'b000} +: 8] != b)
			flags_n[2] = 1'b0;
		if (pos_q >= PW'(OFF_DST_LO) && pos_q <= PW'(OFF_DST_END) &&
			our_addr_low[{~k_lo, 3'b000} +: 8] != b)
			flags_n[3] = 1'b0;
		if (pos_q == PW'(OFF_ICMP) && b != ICMP_ECHO_REQ)
			flags_n[4] = 1'b0;
		vsum_n = vsum_b;
		if ((pos_q >= PW'(OFF_SRC_HI) && pos_q <= PW'(OFF_DST_END)) ||
			(in_dl && pos_q != PW'(OFF_CSUM_HI) && pos_q != PW'(OFF_CSUM_LO)))
			vsum_n = vsum_b + 32'(w);
		// reply sum: addresses, ident/seq and clipped payload
		rsum_n = rsum_b;
		if ((pos_q >= PW'(OFF_SRC_HI) && pos_q <= PW'(OFF_DST_END)) ||
			(pos_q >= PW'(OFF_IDENT) && pos_q <= PW'(OFF_IDENT_END)) || pay)
			rsum_n = rsum_b + 32'(w);
	end

	always_comb begin
		clip_c = dlen_q - 16'd8;
		if (32'(clip_c) > 32'(MAX_ECHO_PAYLOAD))
			clip_c = 16'(MAX_ECHO_PAYLOAD);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			PS_ACC:   if (at_end) state_nxt = PS_SUM;
			PS_SUM:   state_nxt = PS_CHECK;
			PS_CHECK: if (!job_full) state_nxt = PS_ACC;
			default:  state_nxt = PS_ACC;
		endcase
	end

	always_comb begin
		fold_v         = fold_sum(vsum_s1);
		fold_r         = fold_sum(rsum_s1);
		frame.ready    = (state_q == PS_ACC) &&
			!(pend_q != 2'd0 && pos_q >= PW'(OFF_PAYLOAD));
		job_push       = (state_q == PS_CHECK) && !job_full;
		job.consumed   = cons_s1;
		job.reply      = cons_s1 && len_ok_s1 && (fold_v == rcsum_q);
		job.mac        = mac_q;
		job.src_hi     = src_hi_q;
		job.src_lo     = src_lo_q;
		job.ident      = ident_q;
		job.csum       = fold_r;
		job.clip       = clip_s1;
		pay_wr.en      = upd && pay;
		pay_wr.addr    = 16'(pidx >> 3);
		pay_wr.lane    = pidx[2:0];
		pay_wr.data    = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_ACC;
			pos_q   <= '0;
			len_q   <= '0;
			flags_q <= '0;
			vsum_q  <= '0;
			rsum_q  <= '0;
			pend_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (upd) begin
				flags_q <= flags_n;
				vsum_q  <= vsum_n;
				rsum_q  <= rsum_n;
			end
			if (at_end) begin
				len_q <= upd ? pos_q + PW'(1) : pos_q;
				pos_q <= '0;
			end else if (upd) begin
				pos_q <= pos_q + PW'(1);
			end
			pend_q <= pend_q + 2'((job_push && job.reply) ? 1 : 0)
				- 2'(reply_done ? 1 : 0);
		end
	end

	// captured header fields
	always_ff @(posedge clk) begin
		if (upd) begin
			if (pos_q >= PW'(OFF_MAC_SRC) && pos_q <= PW'(OFF_MAC_END))
				mac_q <= {mac_q[39:0], b};
			if (pos_q == PW'(OFF_PLEN_HI) || pos_q == PW'(OFF_PLEN_LO))
				dlen_q <= {dlen_q[7:0], b};
			if (pos_q >= PW'(OFF_SRC_HI) && pos_q < PW'(OFF_SRC_LO))
				src_hi_q <= {src_hi_q[55:0], b};
			if (pos_q >= PW'(OFF_SRC_LO) && pos_q < PW'(OFF_DST_HI))
				src_lo_q <= {src_lo_q[55:0], b};
			if (in_dl && (pos_q == PW'(OFF_CSUM_HI) || pos_q == PW'(OFF_CSUM_LO)))
				rcsum_q <= {rcsum_q[7:0], b};
			if (pos_q >= PW'(OFF_IDENT) && pos_q <= PW'(OFF_IDENT_END))
				ident_q <= {ident_q[23:0], b};
		end
		if (state_q == PS_SUM) begin
			vsum_s1   <= vsum_q + 32'(dlen_q) + 32'(NH_ICMPV6);
			rsum_s1   <= rsum_q + 32'(clip_c) + 32'd8 + 32'(NH_ICMPV6) +
				32'({ICMP_ECHO_REP, 8'd0});
			clip_s1   <= clip_c;
			cons_s1   <= enable && (len_q >= PW'(OFF_PAYLOAD)) && (flags_q == FLAGS_ALL);
			len_ok_s1 <= (dlen_q >= 16'd8) &&
				((32'(dlen_q) + 32'(OFF_ICMP)) <= 32'(len_q));
		end
	end

endmodule

>>> rtl/ier_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_job_fifo
// Two-entry job queue between the parser and the reply generator.
// ----------------------------------------------------------------------------
module ier_job_fifo
	import ier_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic push,
	output logic full,
	output job_t rd_job,
	input  logic pop,
	output logic empty
);

	job_t       slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_job = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push && !full) wptr_q <= ~wptr_q;
			if (pop && !empty) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wptr_q] <= wr_job;
	end

endmodule

>>> rtl/ier_reply_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ier_reply_gen
// Back end: holds the payload memory and turns jobs into verdicts or reply
// words behind an output register.
// ----------------------------------------------------------------------------
module ier_reply_gen
	import ier_pkg::*;
#(
	parameter int MAX_ECHO_PAYLOAD = MAX_ECHO_PAYLOAD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pay_wr_t       pay_wr,
	input  job_t          job,
	input  logic          job_empty,
	output logic          job_pop,
	input  logic [63:0]   our_addr_high,
	input  logic [63:0]   our_addr_low,
	output logic          reply_done,
	ier_result_if.source  result
);

	localparam int WORDS = (MAX_ECHO_PAYLOAD + 7) / 8;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNTW  = $clog2(WORD_PAYLOAD + WORDS + 1);

	logic [63:0] mem [WORDS];
	logic [63:0] rd_q;

	logic            busy_q, ov_q;
	job_t            job_q;
	logic [CNTW-1:0] cnt_q, rcnt;
	logic [15:0]     rem_q;
	res_t            out_q, nxt;

	logic          load, is_pay, fin;
	logic [3:0]    nb;
	logic [63:0]   mask;
	logic [15:0]   msg_len;
	logic [AW-1:0] raddr;

	always_comb begin
		load     = busy_q && (!ov_q || result.ready);
		is_pay   = cnt_q >= CNTW'(WORD_PAYLOAD);
		nb       = (rem_q >= 16'd8) ? 4'd8 : rem_q[3:0];
		msg_len  = job_q.clip + 16'd8;
		for (int j = 0; j < 8; j++)
			mask[63 - 8 * j -: 8] = (4'(j) < nb) ? 8'hFF : 8'h00;
		fin = !job_q.reply ||
			(is_pay ? (rem_q <= 16'd8) :
			 (cnt_q == CNTW'(WORD_ICMP) && job_q.clip == 16'd0));
		nxt.consumed = job_q.consumed;
		nxt.is_reply = job_q.reply;
		nxt.mac      = job_q.reply ? job_q.mac : 48'd0;
		nxt.nbytes   = job_q.reply ? 4'd8 : 4'd0;
		nxt.last     = fin;
		nxt.word     = 64'd0;
		if (job_q.reply) begin
			if (is_pay) begin
				nxt.word   = rd_q & mask;
				nxt.nbytes = nb;
			end else if (cnt_q == CNTW'(WORD_IP6))
				nxt.word = IP6_HDR_WORD0 | {32'd0, msg_len, 16'd0};
			else if (cnt_q == CNTW'(WORD_SRC_HI))
				nxt.word = our_addr_high;
			else if (cnt_q == CNTW'(WORD_SRC_LO))
				nxt.word = our_addr_low;
			else if (cnt_q == CNTW'(WORD_DST_HI))
				nxt.word = job_q.src_hi;
			else if (cnt_q == CNTW'(WORD_DST_LO))
				nxt.word = job_q.src_lo;
			else
				nxt.word = {ICMP_ECHO_REP, 8'd0, job_q.csum, job_q.ident};
		end
		job_pop    = !busy_q && !job_empty;
		reply_done = load && fin && job_q.reply;
		// memory read address for the word that the next load takes
		rcnt  = load ? cnt_q + CNTW'(1) : cnt_q;
		raddr = AW'(rcnt - CNTW'(WORD_PAYLOAD));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (job_pop)
				busy_q <= 1'b1;
			else if (load && fin)
				busy_q <= 1'b0;
			if (load)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			cnt_q <= '0;
			rem_q <= job.clip;
		end else if (load) begin
			cnt_q <= cnt_q + CNTW'(1);
			if (is_pay) rem_q <= rem_q - 16'd8;
		end
		if (load) out_q <= nxt;
	end

	// payload memory, byte-lane writes
	always_ff @(posedge clk) begin
		if (pay_wr.en)
			mem[AW'(pay_wr.addr)][{~pay_wr.lane, 3'b000} +: 8] <= pay_wr.data;
		rd_q <= mem[raddr];
	end

	assign result.valid         = ov_q;
	assign result.consumed      = out_q.consumed;
	assign result.is_reply      = out_q.is_reply;
	assign result.reply_dst_mac = out_q.mac;
	assign result.reply_word    = out_q.word;
	assign result.word_bytes    = out_q.nbytes;
	assign result.last_item     = out_q.last;

endmodule

>>> rtl/icmpv6_echo_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmpv6_echo_responder
// ICMPv6 echo request parser and reply generator.
//
//   channel  dir  payload
//   frame    in   frame_byte, last_byte
//   result   out  consumed, is_reply, reply_dst_mac, reply_word, word_bytes,
//                 last_item
//   cfg      in   cfg_we, cfg_index, cfg_data
//
// One frame byte per cycle is taken while frame.ready is high; after the
// last byte the parser passes its sum and check states (checksum fold and
// verdict) before taking the next frame. A reply leaves at one word per
// cycle while the receiver is ready (payload memory read registered).
// While a reply still drains, the parser holds at the first payload byte
// of the next frame. Reset clears control state, not the payload memory.
// ----------------------------------------------------------------------------
module icmpv6_echo_responder
	import ier_pkg::*;
#(
	parameter int MAX_ECHO_PAYLOAD = MAX_ECHO_PAYLOAD_DEF,
	parameter int MAX_FRAME        = MAX_FRAME_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ier_frame_if.sink     frame,
	ier_result_if.source  result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	logic        enable_q;
	logic [63:0] addr_hi_q, addr_lo_q;

	job_t    job_in, job_out;
	logic    push, full, pop, empty, reply_done;
	pay_wr_t pay_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			addr_hi_q <= '0;
			addr_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_ADDR_HI: addr_hi_q <= cfg_data;
				REG_ADDR_LO: addr_lo_q <= cfg_data;
				// our MAC is not needed: framing is left downstream
				REG_OUR_MAC: ;
				default: ;
			endcase
		end
	end

	ier_parser #(
		.MAX_ECHO_PAYLOAD(MAX_ECHO_PAYLOAD),
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.enable(enable_q),
		.our_addr_high(addr_hi_q),
		.our_addr_low(addr_lo_q),
		.job(job_in),
		.job_push(push),
		.job_full(full),
		.pay_wr(pay_wr),
		.reply_done(reply_done)
	);

	ier_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_job(job_in),
		.push(push),
		.full(full),
		.rd_job(job_out),
		.pop(pop),
		.empty(empty)
	);

	ier_reply_gen #(
		.MAX_ECHO_PAYLOAD(MAX_ECHO_PAYLOAD)
	) u_reply (
		.clk(clk),
		.arst_n(arst_n),
		.pay_wr(pay_wr),
		.job(job_out),
		.job_empty(empty),
		.job_pop(pop),
		.our_addr_high(addr_hi_q),
		.our_addr_low(addr_lo_q),
		.reply_done(reply_done),
		.result(result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");

	a_reply_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_reply |-> result.consumed && result.word_bytes != 4'd0)
		else $error("reply word without consume or bytes");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.is_reply |-> result.last_item && result.word_bytes == 4'd0)
		else $error("verdict not single");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.reply_word))
		else $error("result changed while stalled");

endmodule

>>> verif/tb_icmpv6_echo_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_icmpv6_echo_responder
// Self-checking bench for the ICMPv6 echo responder: frames of bytes go in,
// verdicts and reply words come out and are compared against a byte-level
// predictor of the parser and reply builder, under random idling on both
// channels and several register settings.
// ----------------------------------------------------------------------------
module tb_icmpv6_echo_responder;
	import ier_pkg::*;

	localparam int MAXPAY = 256;
	localparam int MAXFR  = 2048;
	localparam int WDOG_LIMIT = 20000;

	// expected outcome column of the directed table
	localparam int EXP_PREDICT = -1;
	localparam int EXP_DROP    = 0;
	localparam int EXP_CONSUME = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_ENABLE;
	logic [63:0] cfg_data = '0;

	ier_frame_if frame_ch();
	ier_result_if result_ch();

	icmpv6_echo_responder u_top (
		.clk(clk), .arst_n(arst_n), .frame(frame_ch.sink), .result(result_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic        en_r;
	logic [63:0] addr_hi_r, addr_lo_r;
	int unsigned pos;
	logic [47:0] src_mac;
	logic [63:0] src_addr[2];
	logic [31:0] ident_seq;
	logic [15:0] plen_r;
	logic [4:0]  hdr_ok;
	logic [31:0] vsum, rsum;
	logic [15:0] rx_csum;
	logic [7:0]  pay_mem[MAXPAY];

	res_t expected_q[$];
	int errors = 0;
	int frames_sent = 0, replies_seen = 0, results_seen = 0;
	int send_idle_pct = 6, recv_idle_pct = 87;
	int force_exp = EXP_PREDICT;
	bit recv_hold = 0;
	int idle_cycles = 0;

	typedef struct {
		bit en;
		int plen;
		int pay;
		int keep;
		int exp;
	} row_t;

	function automatic logic [15:0] csum_fold(input logic [31:0] s);
		while (s[31:16] != 0)
			s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		return ~s[15:0];
	endfunction

	function automatic logic [31:0] sum_words(input logic [31:0] s, input logic [63:0] v);
		return s + v[63:48] + v[47:32] + v[31:16] + v[15:0];
	endfunction

	function automatic res_t mk(input logic c, r, input logic [47:0] m,
			input logic [63:0] w, input logic [3:0] n, input logic l);
		res_t x;
		x.consumed = c; x.is_reply = r; x.mac = m; x.word = w; x.nbytes = n; x.last = l;
		return x;
	endfunction

	task automatic absorb_byte(input int unsigned p, input logic [7:0] b);
		logic [31:0] w;
		w = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
		if (p == 0) begin
			hdr_ok = FLAGS_ALL; vsum = 0; rsum = 0;
		end
		if (p >= 6 && p <= 11) src_mac = {src_mac[39:0], b};
		if ((p == 12 && b != ETYPE_HI) || (p == 13 && b != ETYPE_LO)) hdr_ok[0] = 1'b0;
		if (p == 18 || p == 19) plen_r = {plen_r[7:0], b};
		if (p == 20 && b != NH_ICMPV6) hdr_ok[1] = 1'b0;
		if (p >= 22 && p <= 29) src_addr[0] = {src_addr[0][55:0], b};
		if (p >= 30 && p <= 37) src_addr[1] = {src_addr[1][55:0], b};
		if (p >= 38 && p <= 45 && addr_hi_r[8*(45-p) +: 8] != b) hdr_ok[2] = 1'b0;
		if (p >= 46 && p <= 53 && addr_lo_r[8*(53-p) +: 8] != b) hdr_ok[3] = 1'b0;
		if (p == 54 && b != ICMP_ECHO_REQ) hdr_ok[4] = 1'b0;
		if (p >= 22 && p <= 53) vsum += w;
		if (p >= 54 && (p - 54) < plen_r) begin
			if (p == 56 || p == 57) rx_csum = {rx_csum[7:0], b};
			else vsum += w;
		end
		if (p >= 58 && p <= 61) ident_seq = {ident_seq[23:0], b};
		if (p >= 62 && (p - 54) < plen_r && (p - 62) < MAXPAY) begin
			pay_mem[p-62] = b; rsum += w;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic lst);
		int unsigned len, clip, msg_len, n;
		logic [31:0] s;
		logic [15:0] cs;
		logic [63:0] wd;
		if (pos < MAXFR) begin
			absorb_byte(pos, b); pos++;
		end
		if (!lst) return;
		len = pos; pos = 0;
		if (force_exp != EXP_PREDICT) begin
			expected_q.push_back(mk(force_exp == EXP_CONSUME, 0, 0, 0, 0, 1)); return;
		end
		if (!en_r || len < 62 || hdr_ok != FLAGS_ALL) begin
			expected_q.push_back(mk(0, 0, 0, 0, 0, 1)); return;
		end
		if (plen_r < 8 || 54 + plen_r > len || csum_fold(vsum + plen_r + 58) != rx_csum) begin
			expected_q.push_back(mk(1, 0, 0, 0, 0, 1)); return;
		end
		clip = plen_r - 8;
		if (clip > MAXPAY) clip = MAXPAY;
		msg_len = 8 + clip;
		s = rsum;
		s = sum_words(s, addr_hi_r); s = sum_words(s, addr_lo_r);
		s = sum_words(s, src_addr[0]); s = sum_words(s, src_addr[1]);
		s += msg_len + 58 + (32'(ICMP_ECHO_REP) << 8) + ident_seq[31:16] + ident_seq[15:0];
		cs = csum_fold(s);
		expected_q.push_back(mk(1, 1, src_mac, IP6_HDR_WORD0 | (64'(msg_len) << 16), 8, 0));
		expected_q.push_back(mk(1, 1, src_mac, addr_hi_r, 8, 0));
		expected_q.push_back(mk(1, 1, src_mac, addr_lo_r, 8, 0));
		expected_q.push_back(mk(1, 1, src_mac, src_addr[0], 8, 0));
		expected_q.push_back(mk(1, 1, src_mac, src_addr[1], 8, 0));
		expected_q.push_back(mk(1, 1, src_mac, {ICMP_ECHO_REP, 8'd0, cs, ident_seq}, 8,
			clip == 0));
		for (int unsigned i = 0; i < clip; i += 8) begin
			n = (clip - i > 8) ? 8 : clip - i;
			wd = '0;
			for (int unsigned j = 0; j < 8; j++)
				wd = {wd[55:0], (j < n) ? pay_mem[i+j] : 8'd0};
			expected_q.push_back(mk(1, 1, src_mac, wd, 4'(n), i + 8 >= clip));
		end
	endtask

	// frame builder
	typedef logic [7:0] bytes_t[$];

	function automatic bytes_t build_echo(input logic [47:0] smac, input logic [63:0] dhi,
			input logic [63:0] dlo, input int plen, input int paylen, input bit good_csum,
			input int pad);
		bytes_t f;
		logic [63:0] shi, slo;
		logic [31:0] s;
		logic [15:0] cs;
		shi = {$urandom, $urandom}; slo = {$urandom, $urandom};
		for (int i = 0; i < 6; i++) f.push_back(8'($urandom));
		for (int i = 0; i < 6; i++) f.push_back(smac[8*(5-i) +: 8]);
		f.push_back(ETYPE_HI); f.push_back(ETYPE_LO);
		f.push_back(8'h60); f.push_back(8'($urandom)); f.push_back(8'($urandom));
		f.push_back(8'($urandom));
		f.push_back(plen[15:8]); f.push_back(plen[7:0]);
		f.push_back(NH_ICMPV6); f.push_back(8'($urandom));
		for (int i = 0; i < 8; i++) f.push_back(shi[8*(7-i) +: 8]);
		for (int i = 0; i < 8; i++) f.push_back(slo[8*(7-i) +: 8]);
		for (int i = 0; i < 8; i++) f.push_back(dhi[8*(7-i) +: 8]);
		for (int i = 0; i < 8; i++) f.push_back(dlo[8*(7-i) +: 8]);
		f.push_back(ICMP_ECHO_REQ); f.push_back(8'd0); f.push_back(8'd0); f.push_back(8'd0);
		for (int i = 0; i < 4 + paylen; i++) f.push_back(8'($urandom));
		// checksum over pseudo-header and the declared message
		s = plen + 58;
		for (int p = 22; p < f.size(); p++)
			if (p <= 53 || ((p - 54) < plen && p != 56 && p != 57))
				s += p[0] ? {24'd0, f[p]} : {16'd0, f[p], 8'd0};
		cs = csum_fold(s);
		if (!good_csum) cs ^= 16'h0100 << $urandom_range(0, 7);
		f[56] = cs[15:8]; f[57] = cs[7:0];
		for (int i = 0; i < pad; i++) f.push_back(8'($urandom));
		return f;
	endfunction

	task automatic send_frame(input bytes_t f);
		for (int i = 0; i < f.size(); i++) begin
			frame_ch.valid <= 1'b1;
			frame_ch.frame_byte <= f[i];
			frame_ch.last_byte <= (i == f.size() - 1);
			@(posedge clk);
			while (!frame_ch.ready) @(posedge clk);
			predict_byte(f[i], i == f.size() - 1);
			// a gap always follows the last byte
			if (i == f.size() - 1 || ($urandom % 100) < send_idle_pct) begin
				frame_ch.valid <= 1'b0;
				@(posedge clk);
				while (($urandom % 100) < send_idle_pct) @(posedge clk);
			end
		end
		frames_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENABLE:  en_r = v[0];
			REG_ADDR_HI: addr_hi_r = v;
			REG_ADDR_LO: addr_lo_r = v;
			// our MAC does not shape the reply
			default: ;
		endcase
	endtask

	task automatic drain_all();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (result_ch.is_reply && result_ch.last_item) replies_seen++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, result_ch.reply_word);
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.consumed !== result_ch.consumed || exp_r.is_reply !== result_ch.is_reply
						|| exp_r.mac !== result_ch.reply_dst_mac || exp_r.word !== result_ch.reply_word
						|| exp_r.nbytes !== result_ch.word_bytes || exp_r.last !== result_ch.last_item) begin
						$display("%0t: mismatch expected %b %b %h %h %0d %b actual %b %b %h %h %0d %b",
							$time, exp_r.consumed, exp_r.is_reply, exp_r.mac, exp_r.word,
							exp_r.nbytes, exp_r.last, result_ch.consumed, result_ch.is_reply,
							result_ch.reply_dst_mac, result_ch.reply_word, result_ch.word_bytes,
							result_ch.last_item);
						errors++;
					end
				end
			end
			result_ch.ready <= !recv_hold && (($urandom % 100) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		bytes_t f;
		int plen;
		row_t rows[4];
		frame_ch.valid = 1'b0; frame_ch.frame_byte = '0; frame_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		en_r = 0; addr_hi_r = 0; addr_lo_r = 0;
		pos = 0; src_mac = 0; src_addr[0] = 0; src_addr[1] = 0; ident_seq = 0;
		plen_r = 0; hdr_ok = 0; vsum = 0; rsum = 0; rx_csum = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_ADDR_HI, 64'hFE80_0000_0000_0000);
		write_reg(REG_ADDR_LO, 64'h0211_22FF_FE33_4455);
		write_reg(REG_OUR_MAC, 64'h0000_0211_2233_4455);

		// directed: disabled after reset, short payload, too-short length, one-byte frame
		rows = '{
			'{1'b0, 8, 0, 0, EXP_DROP},
			'{1'b1, 17, 9, 0, EXP_PREDICT},
			'{1'b1, 7, 0, 0, EXP_CONSUME},
			'{1'b1, 8, 0, 1, EXP_DROP}};
		foreach (rows[r]) begin
			if (rows[r].en != en_r) begin
				drain_all();
				write_reg(REG_ENABLE, 64'(rows[r].en));
			end
			f = build_echo(48'({$urandom, $urandom}), addr_hi_r, addr_lo_r,
				rows[r].plen, rows[r].pay, 1'b1, 0);
			while (rows[r].keep > 0 && f.size() > rows[r].keep) void'(f.pop_back());
			force_exp = rows[r].exp;
			send_frame(f);
			force_exp = EXP_PREDICT;
		end
		drain_all();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 87 : 0;
			recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 6 : 0;
			write_reg(REG_ADDR_HI, phase == 2 ? 64'd0 : {$urandom, $urandom});
			write_reg(REG_ADDR_LO, {$urandom, $urandom});
			write_reg(REG_ENABLE, 1);
			if (phase == 2) fork
				begin recv_hold = 1; repeat (400) @(posedge clk); recv_hold = 0; end
			join_none
			for (int k = 0; k < 6; k++) begin
				if (k == 0) begin
					// echo request: good, bad checksum or one flipped bit
					plen = $urandom_range(8, 16);
					f = build_echo(48'({$urandom, $urandom}), addr_hi_r, addr_lo_r, plen,
						plen - 8, ($urandom % 3) != 1, $urandom_range(0, 2));
					if ($urandom % 3 == 0)
						f[$urandom_range(0, f.size() - 1)] ^= 8'h1 << $urandom_range(0, 7);
				end else begin
					f = {};
					for (int i = $urandom_range(1, 2); i > 0; i--) f.push_back(8'($urandom));
				end
				send_frame(f);
			end
			drain_all();
		end

		$display("covered %0d frames, %0d replies, %0d result words", frames_sent,
			replies_seen, results_seen);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
rtl/ier_pkg.sv
rtl/ier_frame_if.sv
rtl/ier_result_if.sv
rtl/ier_parser.sv
rtl/ier_job_fifo.sv
rtl/ier_reply_gen.sv
rtl/icmpv6_echo_responder.sv
verif/tb_icmpv6_echo_responder.sv
